>>> sv/uaf_pkg.sv
// Shared types, constants and the accent fold table for the UTF-8 accent folder.
package uaf_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned CHAR_W  = 7;
   localparam int unsigned COUNT_W = 10;
   localparam int unsigned SKIP_W  = 2;

   localparam logic [BYTE_W-1:0]  LEAD_C3     = 8'hC3;
   localparam logic [BYTE_W-1:0]  LEAD_4BYTE  = 8'hF0;
   localparam logic [BYTE_W-1:0]  LEAD_3BYTE  = 8'hE0;
   localparam logic [BYTE_W-1:0]  LEAD_2BYTE  = 8'hC0;
   localparam logic [BYTE_W-1:0]  ASCII_LIMIT = 8'h80;
   localparam logic [CHAR_W-1:0]  QMARK       = 7'h3F;
   localparam logic [CHAR_W-1:0]  TERM_CHAR   = 7'h00;
   localparam logic [COUNT_W-1:0] MAX_CHARS_RESET = 10'd255;

   localparam logic [SKIP_W-1:0] SKIP_4BYTE = 2'd3;
   localparam logic [SKIP_W-1:0] SKIP_3BYTE = 2'd2;
   localparam logic [SKIP_W-1:0] SKIP_2BYTE = 2'd1;
   localparam logic [SKIP_W-1:0] SKIP_NONE  = 2'd0;

   // Result queue geometry
   localparam int unsigned QDEPTH  = 4;
   localparam int unsigned QPTR_W  = $clog2(QDEPTH);
   localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);
   localparam logic [QCNT_W-1:0] QROOM_LIMIT = QCNT_W'(QDEPTH - 2);

   typedef struct packed {
      logic [CHAR_W-1:0] out_char;
      logic              out_last;
   } result_type;

   // Up to two results per item, both written into the queue in the same cycle
   typedef struct packed {
      logic [1:0] num;
      result_type r0;
      result_type r1;
   } push_type;

   // Plain letter for the second byte after 0xC3 (low six bits); 0 means no fold
   function automatic logic [CHAR_W-1:0] fold_letter(input logic [5:0] idx);
      logic [CHAR_W-1:0] ch;
      unique case (idx)
         6'd0, 6'd2, 6'd4:             ch = 7'h41; // A
         6'd7:                         ch = 7'h43; // C
         6'd8, 6'd9, 6'd10, 6'd11:     ch = 7'h45; // E
         6'd14, 6'd15:                 ch = 7'h49; // I
         6'd20, 6'd22:                 ch = 7'h4F; // O
         6'd25, 6'd27, 6'd28:          ch = 7'h55; // U
         6'd32, 6'd34, 6'd36:          ch = 7'h61; // a
         6'd39:                        ch = 7'h63; // c
         6'd40, 6'd41, 6'd42, 6'd43:   ch = 7'h65; // e
         6'd46, 6'd47:                 ch = 7'h69; // i
         6'd52, 6'd54:                 ch = 7'h6F; // o
         6'd57, 6'd59, 6'd60:          ch = 7'h75; // u
         6'd63:                        ch = 7'h79; // y
         default:                      ch = 7'h00;
      endcase
      return ch;
   endfunction

endpackage

>>> sv/uaf_fold.sv
// Input register, sequence state and per-byte fold decode.
module uaf_fold import uaf_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [BYTE_W-1:0]   req_in_byte,
   input  logic [COUNT_W-1:0]  max_chars,
   input  logic                room,
   output push_type            push
);

   logic                valid_ff, valid_in;
   logic [BYTE_W-1:0]   byte_ff;
   logic [SKIP_W-1:0]   skip_ff, skip_in;
   logic                after_c3_ff, after_c3_in;
   logic [COUNT_W-1:0]  emitted_ff, emitted_in;
   logic                advance;
   logic                has_room;
   logic [CHAR_W-1:0]   folded;

   assign advance   = valid_ff && room;
   assign req_ready = !valid_ff || room;
   assign valid_in  = req_ready ? req_valid : valid_ff;
   assign has_room  = emitted_ff < max_chars;
   assign folded    = fold_letter(byte_ff[5:0]);

   always_comb begin
      push         = '0;
      skip_in      = skip_ff;
      after_c3_in  = after_c3_ff;
      emitted_in   = emitted_ff;
      if (advance) begin
         priority if (byte_ff == '0) begin
            if (after_c3_ff && has_room) begin
               push.num = 2'd2;
               push.r0  = '{out_char: QMARK, out_last: 1'b0};
               push.r1  = '{out_char: TERM_CHAR, out_last: 1'b1};
            end else begin
               push.num = 2'd1;
               push.r0  = '{out_char: TERM_CHAR, out_last: 1'b1};
            end
            skip_in     = SKIP_NONE;
            after_c3_in = 1'b0;
            emitted_in  = '0;
         end else if (after_c3_ff) begin
            after_c3_in = 1'b0;
            if (has_room) begin
               push.num = 2'd1;
               push.r0.out_char =
                  (byte_ff[7:6] == 2'b10 && folded != '0) ? folded : QMARK;
               emitted_in = emitted_ff + 1'b1;
            end
         end else if (skip_ff != SKIP_NONE) begin
            skip_in = skip_ff - 1'b1;
         end else if (!has_room) begin
            // max_chars reached: byte dropped until the terminator
         end else if (byte_ff < ASCII_LIMIT) begin
            push.num = 2'd1;
            push.r0.out_char = byte_ff[CHAR_W-1:0];
            emitted_in = emitted_ff + 1'b1;
         end else if (byte_ff == LEAD_C3) begin
            after_c3_in = 1'b1;
         end else begin
            priority if (byte_ff >= LEAD_4BYTE) skip_in = SKIP_4BYTE;
            else if (byte_ff >= LEAD_3BYTE)     skip_in = SKIP_3BYTE;
            else if (byte_ff >= LEAD_2BYTE)     skip_in = SKIP_2BYTE;
            else                                skip_in = SKIP_NONE;
            push.num = 2'd1;
            push.r0.out_char = QMARK;
            emitted_in = emitted_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         skip_ff     <= SKIP_NONE;
         after_c3_ff <= 1'b0;
         emitted_ff  <= '0;
      end else begin
         valid_ff    <= valid_in;
         skip_ff     <= skip_in;
         after_c3_ff <= after_c3_in;
         emitted_ff  <= emitted_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready) begin
         byte_ff <= req_in_byte;
      end
   end

endmodule

>>> sv/uaf_out_queue.sv
// Small result queue: takes up to two results a cycle, hands out one.
module uaf_out_queue import uaf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  push_type           push,
   output logic               room,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAR_W-1:0]  rsp_out_char,
   output logic               rsp_out_last
);

   result_type          entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic [QPTR_W-1:0]   wr_ptr_next;
   logic                pop;

   assign pop          = rsp_valid && rsp_ready;
   assign rsp_valid    = count_ff != '0;
   assign rsp_out_char = entry_ff[rd_ptr_ff].out_char;
   assign rsp_out_last = entry_ff[rd_ptr_ff].out_last;
   // room for two more results regardless of this cycle's pop
   assign room         = count_ff <= QROOM_LIMIT;
   assign wr_ptr_next  = wr_ptr_ff + 1'b1;

   assign wr_ptr_in = wr_ptr_ff + QPTR_W'(push.num);
   assign rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   assign count_in  = count_ff + QCNT_W'(push.num) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.num != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.r0;
      end
      if (push.num == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.r1;
      end
   end

endmodule

>>> sv/utf8_accent_fold.sv
// UTF-8 to ASCII accent folder: top level with the max_chars register.
// Bytes go from the input register to the result queue. Throughput: one byte
// per cycle while the queue has room; a terminator after a 0xC3 lead gives
// two results below max_chars, which leave the four-entry queue one per cycle.
// Reset: sequence state, count and queue cleared; max_chars set to 255.
module utf8_accent_fold import uaf_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [BYTE_W-1:0]  req_in_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [CHAR_W-1:0]  rsp_out_char,
   output logic               rsp_out_last,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [COUNT_W-1:0] csr_max_chars
);

   logic [COUNT_W-1:0] max_chars_ff, max_chars_in;
   logic               room;
   push_type           push;

   assign csr_ready    = 1'b1;
   assign max_chars_in = (csr_valid && csr_ready) ? csr_max_chars : max_chars_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_chars_ff <= MAX_CHARS_RESET;
      end else begin
         max_chars_ff <= max_chars_in;
      end
   end

   uaf_fold u_fold (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .max_chars   (max_chars_ff),
      .room        (room),
      .push        (push)
   );

   uaf_out_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room         (room),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_char (rsp_out_char),
      .rsp_out_last (rsp_out_last)
   );

endmodule
